// ===== hw/rtl/aabb_point_query_unit_assert.svh =====
// Assertion macros shared by the point query unit.
// Included by the top level; needs no other file.
`ifndef AABB_POINT_QUERY_UNIT_ASSERT_SVH
`define AABB_POINT_QUERY_UNIT_ASSERT_SVH

// Same-cycle implication under active-low synchronous reset
`define AABBPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("point query assertion failed");

// Next-cycle implication under active-low synchronous reset
`define AABBPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("point query assertion failed");

`endif

// ===== hw/rtl/aabbpq_pkg.sv =====
// Package of the point query unit: widths, codes, beat and job types.
// No dependencies.
package aabbpq_pkg;

    localparam int COORD_BITS = 24;
    localparam int DIST_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * COORD_BITS;
    localparam int SUM_BITS   = SQ_BITS + 2;
    localparam int ROOT_BITS  = SUM_BITS / 2;
    localparam int FIFO_DEPTH = 4;
    localparam int NUM_REGS   = 7;
    localparam int ADDR_BITS  = 5;

    typedef enum logic [1:0] {
        MODE_INVALID  = 2'd0,
        MODE_FINITE   = 2'd1,
        MODE_INFINITE = 2'd2,
        MODE_UNUSED   = 2'd3
    } t_box_mode;

    typedef enum logic [2:0] {
        REG_BOX_MODE = 3'd0,
        REG_LOWER_X  = 3'd1,
        REG_LOWER_Y  = 3'd2,
        REG_LOWER_Z  = 3'd3,
        REG_UPPER_X  = 3'd4,
        REG_UPPER_Y  = 3'd5,
        REG_UPPER_Z  = 3'd6,
        REG_NONE     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] point_z;
    } t_point;

    typedef struct packed {
        logic                 inside_res;
        logic [DIST_BITS-1:0] near_dist;
        logic [DIST_BITS-1:0] far_dist;
    } t_result;

    typedef struct packed {
        t_box_mode                  mode;
        logic [2:0][COORD_BITS-1:0] corner_a;
        logic [2:0][COORD_BITS-1:0] corner_b;
    } t_box;

    // Classified point handed from front to back
    typedef struct packed {
        logic                       sat;
        logic                       in_box;
        logic [2:0][COORD_BITS-1:0] dn;
        logic [2:0][COORD_BITS-1:0] df;
    } t_job;

endpackage

// ===== hw/rtl/aabbpq_front.sv =====
// Front end: orders the box corners and reduces a point to per-axis distances.
// Depends on aabbpq_pkg.
module aabbpq_front (
    input  aabbpq_pkg::t_box   i_box,
    input  aabbpq_pkg::t_point i_point,
    output aabbpq_pkg::t_job   o_job
);
    localparam int C = aabbpq_pkg::COORD_BITS;

    logic signed [C-1:0] a [3];
    logic signed [C-1:0] b [3];
    logic signed [C-1:0] lo [3];
    logic signed [C-1:0] hi [3];
    logic signed [C-1:0] p [3];
    logic signed [C:0]   d_lo [3];
    logic signed [C:0]   d_hi [3];
    logic signed [C+1:0] two_p [3];
    logic signed [C+1:0] mid_sum [3];

    assign p[0] = i_point.point_x;
    assign p[1] = i_point.point_y;
    assign p[2] = i_point.point_z;

    // Per-axis lanes
    always_comb begin
        o_job.sat    = (i_box.mode != aabbpq_pkg::MODE_FINITE);
        o_job.in_box = 1'b1;
        o_job.dn     = '0;
        o_job.df     = '0;
        for (int i = 0; i < 3; i++) begin
            a[i]  = $signed(i_box.corner_a[2-i]);
            b[i]  = $signed(i_box.corner_b[2-i]);
            lo[i] = (a[i] < b[i]) ? a[i] : b[i];
            hi[i] = (a[i] < b[i]) ? b[i] : a[i];
            d_lo[i] = {lo[i][C-1], lo[i]} - {p[i][C-1], p[i]};
            d_hi[i] = {p[i][C-1], p[i]} - {hi[i][C-1], hi[i]};
            two_p[i]   = {p[i][C-1], p[i], 1'b0};
            mid_sum[i] = {{2{lo[i][C-1]}}, lo[i]} + {{2{hi[i][C-1]}}, hi[i]};
            if (p[i] < lo[i] || p[i] > hi[i]) begin
                o_job.in_box = 1'b0;
            end
            if (lo[i] > p[i]) begin
                o_job.dn[i] = d_lo[i][C-1:0];
            end else if (hi[i] < p[i]) begin
                o_job.dn[i] = d_hi[i][C-1:0];
            end
            // farthest corner: upper when below the centre, lower otherwise
            if (two_p[i] < mid_sum[i]) begin
                o_job.df[i] = C'(-d_hi[i]);
            end else begin
                o_job.df[i] = C'(-d_lo[i]);
            end
        end
        // non-finite boxes: containment follows the mode, distances are fixed
        if (o_job.sat) begin
            o_job.in_box = (i_box.mode == aabbpq_pkg::MODE_INFINITE);
            o_job.dn     = '0;
            o_job.df     = '0;
        end
    end
endmodule

// ===== hw/rtl/aabbpq_fifo.sv =====
// Short job queue between front and back end.
// Depends on aabbpq_pkg.
module aabbpq_fifo #(
    parameter int DEPTH = aabbpq_pkg::FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  aabbpq_pkg::t_job i_wdata,
    input  logic             i_rd,
    output aabbpq_pkg::t_job o_rdata,
    output logic             o_full,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    aabbpq_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          wr_ok, rd_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    // Pointer and count update
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (wr_ok) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (rd_ok) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (wr_ok && !rd_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_ok && !wr_ok) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_wdata;
        end
    end
endmodule

// ===== hw/rtl/aabbpq_back.sv =====
// Back end: squares, sums, two pipelined square roots and the result register.
// Depends on aabbpq_pkg.
module aabbpq_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  aabbpq_pkg::t_job    i_job,
    input  logic                i_job_vld,
    output logic                o_job_take,
    input  logic                i_pop,
    output logic                o_empty,
    output aabbpq_pkg::t_result o_result
);
    localparam int SQ = aabbpq_pkg::SQ_BITS;
    localparam int SW = aabbpq_pkg::SUM_BITS;
    localparam int RB = aabbpq_pkg::ROOT_BITS;
    localparam int TW = SW + 2;

    logic en;
    // whole pipeline advances unless the result register is held
    logic r_out_vld;
    assign en         = !r_out_vld || i_pop;
    assign o_job_take = en && i_job_vld;
    assign o_empty    = !r_out_vld;

    // Square stage
    logic                r_sq_vld;
    logic [SQ-1:0]       r_sq_n [3];
    logic [SQ-1:0]       r_sq_f [3];
    logic                r_sq_sat, r_sq_in;

    // Sum stage and root pipeline (index 0 is the sum)
    logic          r_vld [RB+1];
    logic          r_sat [RB+1];
    logic          r_in  [RB+1];
    logic [SW-1:0] r_rem_n [RB+1];
    logic [SW-1:0] r_rem_f [RB+1];
    logic [RB-1:0] r_rt_n  [RB+1];
    logic [RB-1:0] r_rt_f  [RB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= 1'b0;
            r_vld[0] <= 1'b0;
        end else if (en) begin
            r_sq_vld <= i_job_vld;
            r_vld[0] <= r_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq_n[i] <= i_job.dn[i] * i_job.dn[i];
                r_sq_f[i] <= i_job.df[i] * i_job.df[i];
            end
            r_sq_sat   <= i_job.sat;
            r_sq_in    <= i_job.in_box;
            r_rem_n[0] <= SW'(r_sq_n[0]) + SW'(r_sq_n[1]) + SW'(r_sq_n[2]);
            r_rem_f[0] <= SW'(r_sq_f[0]) + SW'(r_sq_f[1]) + SW'(r_sq_f[2]);
            r_rt_n[0]  <= '0;
            r_rt_f[0]  <= '0;
            r_sat[0]   <= r_sq_sat;
            r_in[0]    <= r_sq_in;
        end
    end

    // One root bit per stage, most significant first
    for (genvar k = 0; k < RB; k++) begin : g_root
        localparam int BP = RB - 1 - k;
        logic [TW-1:0] trial_n, trial_f;
        assign trial_n = (TW'(r_rt_n[k]) << (BP + 1)) + (TW'(1) << (2 * BP));
        assign trial_f = (TW'(r_rt_f[k]) << (BP + 1)) + (TW'(1) << (2 * BP));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sat[k+1] <= r_sat[k];
                r_in[k+1]  <= r_in[k];
                if (TW'(r_rem_n[k]) >= trial_n) begin
                    r_rem_n[k+1] <= r_rem_n[k] - SW'(trial_n);
                    r_rt_n[k+1]  <= r_rt_n[k] | (RB'(1) << BP);
                end else begin
                    r_rem_n[k+1] <= r_rem_n[k];
                    r_rt_n[k+1]  <= r_rt_n[k];
                end
                if (TW'(r_rem_f[k]) >= trial_f) begin
                    r_rem_f[k+1] <= r_rem_f[k] - SW'(trial_f);
                    r_rt_f[k+1]  <= r_rt_f[k] | (RB'(1) << BP);
                end else begin
                    r_rem_f[k+1] <= r_rem_f[k];
                    r_rt_f[k+1]  <= r_rt_f[k];
                end
            end
        end
    end

    // Result register
    aabbpq_pkg::t_result r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld[RB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.inside_res <= r_in[RB];
            r_out.near_dist  <= aabbpq_pkg::DIST_BITS'(r_rt_n[RB]);
            r_out.far_dist   <= r_sat[RB] ? '1 : aabbpq_pkg::DIST_BITS'(r_rt_f[RB]);
        end
    end

    assign o_result = r_out;
endmodule

// ===== hw/rtl/aabb_point_query_unit.sv =====
// Top level of the point query unit: configuration registers, front, queue, back.
// Depends on aabbpq_pkg, aabbpq_front, aabbpq_fifo, aabbpq_back and the assert header.
//
// Usage: program the box over the register port (mode at 0x00, first corner x/y/z
// at 0x04..0x0C, second corner x/y/z at 0x10..0x18) while no query is in flight.
// Query points enter with push while full is low; one beat carries x, y, z.
// Each point yields one result beat: containment flag, distance to the nearest
// box point and distance to the farthest corner, both floored Q25.0.
// Throughput: one point per cycle, sustained while the result side pops.
// Path: a pushed point is written into the queue, which hands it on to the
// square stage; the sums, the 25-stage square root pipeline (one root bit
// per stage) and the result register follow in that order.
// When pop stays low the back pipeline holds in place, the queue fills and
// full rises after the queue's four entries are taken. Reset empties the
// pipeline and queue and clears all registers to an invalid box at the origin.
`include "aabb_point_query_unit_assert.svh"

module aabb_point_query_unit #(
    parameter int FIFO_DEPTH = aabbpq_pkg::FIFO_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  aabbpq_pkg::t_point                  i_point,
    output logic                                empty,
    input  logic                                pop,
    output aabbpq_pkg::t_result                 o_result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [aabbpq_pkg::ADDR_BITS-1:0]    paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    localparam int C = aabbpq_pkg::COORD_BITS;

    aabbpq_pkg::t_box    r_box;
    aabbpq_pkg::t_reg_idx reg_idx;
    logic                cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = aabbpq_pkg::t_reg_idx'(paddr[4:2]);

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box.mode     <= aabbpq_pkg::MODE_INVALID;
            r_box.corner_a <= '0;
            r_box.corner_b <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                aabbpq_pkg::REG_BOX_MODE: r_box.mode <= aabbpq_pkg::t_box_mode'(pwdata[1:0]);
                aabbpq_pkg::REG_LOWER_X:  r_box.corner_a[2] <= pwdata[C-1:0];
                aabbpq_pkg::REG_LOWER_Y:  r_box.corner_a[1] <= pwdata[C-1:0];
                aabbpq_pkg::REG_LOWER_Z:  r_box.corner_a[0] <= pwdata[C-1:0];
                aabbpq_pkg::REG_UPPER_X:  r_box.corner_b[2] <= pwdata[C-1:0];
                aabbpq_pkg::REG_UPPER_Y:  r_box.corner_b[1] <= pwdata[C-1:0];
                aabbpq_pkg::REG_UPPER_Z:  r_box.corner_b[0] <= pwdata[C-1:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (reg_idx)
            aabbpq_pkg::REG_BOX_MODE: prdata = 32'(r_box.mode);
            aabbpq_pkg::REG_LOWER_X:  prdata = 32'(r_box.corner_a[2]);
            aabbpq_pkg::REG_LOWER_Y:  prdata = 32'(r_box.corner_a[1]);
            aabbpq_pkg::REG_LOWER_Z:  prdata = 32'(r_box.corner_a[0]);
            aabbpq_pkg::REG_UPPER_X:  prdata = 32'(r_box.corner_b[2]);
            aabbpq_pkg::REG_UPPER_Y:  prdata = 32'(r_box.corner_b[1]);
            aabbpq_pkg::REG_UPPER_Z:  prdata = 32'(r_box.corner_b[0]);
            default:                  prdata = '0;
        endcase
    end

    // Front: classify the incoming beat
    aabbpq_pkg::t_job front_job, q_job;
    logic             q_empty, q_take;

    aabbpq_front u_front (
        .i_box   (r_box),
        .i_point (i_point),
        .o_job   (front_job)
    );

    aabbpq_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_wdata (front_job),
        .i_rd    (q_take),
        .o_rdata (q_job),
        .o_full  (full),
        .o_empty (q_empty)
    );

    aabbpq_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (q_job),
        .i_job_vld  (!q_empty),
        .o_job_take (q_take),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_result   (o_result)
    );

    // Checks
    `AABBPQ_ASSERT_IMP(a_far_sat, i_clk, i_rst_n, !empty && r_box.mode != aabbpq_pkg::MODE_FINITE, o_result.far_dist == '1)
    `AABBPQ_ASSERT_IMP(a_near_zero, i_clk, i_rst_n, !empty && o_result.inside_res, o_result.near_dist == '0)
    `AABBPQ_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, !empty && !pop && full, full)
endmodule

// ===== bench/tb_aabb_point_query_unit.sv =====
// Self-checking bench for the point query unit: directed table, then random points.
// Depends on aabbpq_pkg and the aabb_point_query_unit top level.
`timescale 1ns / 100ps

module tb_aabb_point_query_unit;
    import aabbpq_pkg::*;

    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
    localparam int LATENCY = 40;

    logic i_clk;
    logic i_rst_n;
    logic push;
    logic full;
    t_point i_point;
    logic empty;
    logic pop;
    t_result o_result;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    aabb_point_query_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_point(i_point),
        .empty(empty), .pop(pop), .o_result(o_result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow copy of the box registers
    logic [1:0] box_mode_q;
    logic [2:0][COORD_BITS-1:0] corner_a_q;
    logic [2:0][COORD_BITS-1:0] corner_b_q;

    t_result result_queue[$];
    int      errors;
    int      send_idle;
    int      recv_stall;

    // one directed row: a point and, where obvious, the result
    typedef struct packed {
        t_point  pt;
        logic    known;
        t_result res;
    } t_row;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        begin
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        end
    endfunction

    // distances and containment for one point against the shadow box
    function automatic t_result query_box(input t_point pt);
        t_result res;
        logic signed [COORD_BITS+1:0] a, b, lo, hi, p, dn, df;
        logic [63:0] near_sum, far_sum, rt;
        logic [2:0][COORD_BITS-1:0] pv;
        begin
            // index 0 is x, matching the shadow corners
            pv = {pt.point_z, pt.point_y, pt.point_x};
            res.inside_res = 1'b1;
            near_sum = 0;
            far_sum = 0;
            if (box_mode_q != MODE_FINITE) begin
                res.inside_res = (box_mode_q == MODE_INFINITE);
                res.near_dist = '0;
                res.far_dist = DIST_MAX;
                return res;
            end
            for (int i = 0; i < 3; i++) begin
                a = signed'(corner_a_q[i]);
                b = signed'(corner_b_q[i]);
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
                p = signed'(pv[i]);
                if (p < lo || p > hi) res.inside_res = 1'b0;
                dn = (lo > p) ? lo - p : (hi < p) ? p - hi : 0;
                df = (2 * p < lo + hi) ? hi - p : p - lo;
                near_sum += 64'(dn) * 64'(dn);
                far_sum += 64'(df) * 64'(df);
            end
            rt = isqrt64(near_sum);
            res.near_dist = (rt > DIST_MAX) ? DIST_MAX : rt[DIST_BITS-1:0];
            rt = isqrt64(far_sum);
            res.far_dist = (rt > DIST_MAX) ? DIST_MAX : rt[DIST_BITS-1:0];
            return res;
        end
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_BITS'(4 * idx);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_BOX_MODE) box_mode_q = value[1:0];
        else if (idx <= REG_LOWER_Z) corner_a_q[idx - 1] = value[COORD_BITS-1:0];
        else corner_b_q[idx - 4] = value[COORD_BITS-1:0];
    endtask

    // wait out the pipeline before touching the box
    task automatic drain;
        push <= 1'b0;
        while (result_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic set_box(input logic [1:0] mode, input logic [2:0][COORD_BITS-1:0] ca,
                           input logic [2:0][COORD_BITS-1:0] cb);
        drain();
        write_reg(REG_BOX_MODE, 32'(mode));
        write_reg(REG_LOWER_X, 32'(ca[0]));
        write_reg(REG_LOWER_Y, 32'(ca[1]));
        write_reg(REG_LOWER_Z, 32'(ca[2]));
        write_reg(REG_UPPER_X, 32'(cb[0]));
        write_reg(REG_UPPER_Y, 32'(cb[1]));
        write_reg(REG_UPPER_Z, 32'(cb[2]));
    endtask

    // send one beat, with random gaps ahead of it; push stays high between beats
    task automatic send_point(input t_point pt, input logic known, input t_result res);
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_point <= pt;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        result_queue.push_back(known ? res : query_box(pt));
    endtask

    function automatic logic [COORD_BITS-1:0] rand_coord(input int span);
        case ($urandom_range(5))
            0: return COORD_BITS'($urandom);
            1: return {1'b1, {(COORD_BITS-1){1'b0}}};
            2: return {1'b0, {(COORD_BITS-1){1'b1}}};
            default: return COORD_BITS'($urandom_range(2 * span) - span);
        endcase
    endfunction

    // result side: random pop stalls, compare against oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (result_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_result);
                errors++;
            end else begin
                t_result exp_res;
                exp_res = result_queue.pop_front();
                if (o_result.inside_res !== exp_res.inside_res) begin
                    $display("%0t: inside expected %b actual %b", $time,
                             exp_res.inside_res, o_result.inside_res);
                    errors++;
                end
                if (o_result.near_dist !== exp_res.near_dist) begin
                    $display("%0t: near expected %0d actual %0d", $time,
                             exp_res.near_dist, o_result.near_dist);
                    errors++;
                end
                if (o_result.far_dist !== exp_res.far_dist) begin
                    $display("%0t: far expected %0d actual %0d", $time,
                             exp_res.far_dist, o_result.far_dist);
                    errors++;
                end
            end
        end
        pop <= ($urandom_range(99) >= recv_stall);
    end

    localparam logic [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    initial begin
        t_row rows[$];
        t_row row;
        t_point pt;
        t_result none_res;
        logic [2:0][COORD_BITS-1:0] ca, cb;
        int span;

        errors = 0;
        send_idle = 0;
        recv_stall = 0;
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_point = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        box_mode_q = MODE_INVALID;
        corner_a_q = '0;
        corner_b_q = '0;
        none_res = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: invalid box
        rows.push_back('{'{24'd5, 24'd6, 24'd7}, 1'b1, '{1'b0, '0, DIST_MAX}});
        rows.push_back('{'{CMAX, CMIN, CMAX}, 1'b1, '{1'b0, '0, DIST_MAX}});
        foreach (rows[i]) send_point(rows[i].pt, rows[i].known, rows[i].res);
        rows.delete();

        // infinite and unused mode
        set_box(MODE_INFINITE, '0, '0);
        send_point('{CMIN, CMIN, CMIN}, 1'b1, '{1'b1, '0, DIST_MAX});
        set_box(MODE_UNUSED, '0, '0);
        send_point('{CMAX, CMAX, CMAX}, 1'b1, '{1'b0, '0, DIST_MAX});

        // finite box with swapped corners; extremes, centre tie, faces
        ca = '{24'd512, -24'sd256, 24'd1000};
        cb = '{-24'sd512, 24'd256, -24'sd1000};
        set_box(MODE_FINITE, ca, cb);
        rows.push_back('{'{24'd0, 24'd0, 24'd0}, 1'b0, none_res});
        rows.push_back('{'{24'd512, 24'd256, 24'd1000}, 1'b0, none_res});
        rows.push_back('{'{-24'sd512, -24'sd256, -24'sd1000}, 1'b0, none_res});
        rows.push_back('{'{24'd513, 24'd0, 24'd0}, 1'b0, none_res});
        rows.push_back('{'{CMIN, CMIN, CMIN}, 1'b0, none_res});
        rows.push_back('{'{CMAX, CMAX, CMAX}, 1'b0, none_res});
        rows.push_back('{'{CMIN, CMAX, CMIN}, 1'b0, none_res});
        rows.push_back('{'{24'd1, -24'sd1, 24'd1}, 1'b0, none_res});
        foreach (rows[i]) send_point(rows[i].pt, rows[i].known, rows[i].res);

        // extreme box: full range on every axis
        set_box(MODE_FINITE, '{CMIN, CMIN, CMIN}, '{CMAX, CMAX, CMAX});
        foreach (rows[i]) send_point(rows[i].pt, rows[i].known, rows[i].res);
        set_box(MODE_FINITE, '{CMAX, CMAX, CMAX}, '{CMAX, CMAX, CMAX});
        send_point('{CMIN, CMIN, CMIN}, 1'b0, none_res);
        send_point('{CMAX, CMAX, CMAX}, 1'b1, '{1'b1, '0, '0});

        // random phases with differing idle mixes
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 56; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 56; end
                default: begin send_idle = 32; recv_stall = 32; end
            endcase
            span = (ph % 2) ? 4000 : 8388607;
            for (int i = 0; i < 3; i++) begin
                ca[i] = rand_coord(span);
                cb[i] = rand_coord(span);
            end
            set_box(($urandom_range(9) < 8) ? MODE_FINITE : 2'($urandom), ca, cb);
            for (int n = 0; n < 55; n++) begin
                pt.point_x = rand_coord(span);
                pt.point_y = rand_coord(span);
                pt.point_z = rand_coord(span);
                send_point(pt, 1'b0, none_res);
            end
        end

        drain();
        if (errors == 0 && result_queue.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
